### hw/rtl/ezvad_pkg.sv
package ezvad_pkg;

	// Frame and length limits
	localparam int FRAME_MAX  = 4096;
	localparam int LEN_W      = 24;
	localparam int CNT_W      = $clog2(FRAME_MAX + 1);

	// Datapath widths
	localparam int SAMPLE_W   = 16;
	localparam int MIX_W      = SAMPLE_W + 1;
	localparam int SQ_W       = 2 * SAMPLE_W + 1;
	localparam int ENERGY_W   = 44;
	localparam int ETHR_W     = 33;
	localparam int ZTHR_W     = 17;
	localparam int ZCR_SHIFT  = 16;
	localparam int ELIM_W     = ETHR_W + CNT_W;
	localparam int ZLIM_W     = ZTHR_W + CNT_W;
	localparam int ECMP_W     = (ENERGY_W > ELIM_W) ? ENERGY_W : ELIM_W;

	// Port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ETHR_W;
	localparam int S_DATA_W   = 2 * SAMPLE_W;
	localparam int M_DATA_W   = 8 * ((LEN_W + 2 + 7) / 8);

	// Register reset values
	localparam logic              RST_CHANNEL_MODE = 1'b1;
	localparam logic [ETHR_W-1:0] RST_ENERGY_THR   = ETHR_W'(17179869);
	localparam logic [ZTHR_W-1:0] RST_ZCR_THR      = ZTHR_W'(6554);
	localparam logic [LEN_W-1:0]  RST_SILENCE      = LEN_W'(19200);
	localparam logic [LEN_W-1:0]  RST_MIN_SEGMENT  = LEN_W'(6400);
	localparam logic [LEN_W-1:0]  RST_FLUSH_MIN    = LEN_W'(3200);

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_START    = 2'd1,
		EV_COMPLETE = 2'd2,
		EV_DISCARD  = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_MODE  = 3'd0,
		CFG_ENERGY_THR    = 3'd1,
		CFG_ZCR_THR       = 3'd2,
		CFG_SILENCE_LIMIT = 3'd3,
		CFG_MIN_SEGMENT   = 3'd4,
		CFG_FLUSH_MIN     = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic              channel_mode;
		logic [ETHR_W-1:0] energy_thr;
		logic [ZTHR_W-1:0] zcr_thr;
		logic [LEN_W-1:0]  silence_limit;
		logic [LEN_W-1:0]  min_segment;
		logic [LEN_W-1:0]  flush_min;
	} cfg_t;

	typedef struct packed {
		logic            flush;
		logic            last;
		logic            nn;
		logic [SQ_W-1:0] sq;
	} sq_t;

	typedef struct packed {
		logic                flush;
		logic [ENERGY_W-1:0] energy;
		logic [CNT_W-1:0]    crossings;
		logic [CNT_W-1:0]    n;
	} frame_t;

	typedef struct packed {
		logic                flush;
		logic [ENERGY_W-1:0] energy;
		logic [CNT_W-1:0]    crossings;
		logic [CNT_W-1:0]    n;
		logic [ELIM_W-1:0]   elim;
		logic [ZLIM_W-1:0]   zlim;
	} prod_t;

endpackage

### hw/rtl/ezvad_cfg.sv
module ezvad_cfg import ezvad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Indexes past the list fall to the default arm and change nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_mode  <= RST_CHANNEL_MODE;
			cfg_q.energy_thr    <= RST_ENERGY_THR;
			cfg_q.zcr_thr       <= RST_ZCR_THR;
			cfg_q.silence_limit <= RST_SILENCE;
			cfg_q.min_segment   <= RST_MIN_SEGMENT;
			cfg_q.flush_min     <= RST_FLUSH_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL_MODE:  cfg_q.channel_mode  <= cfg_data[0];
				CFG_ENERGY_THR:    cfg_q.energy_thr    <= cfg_data[ETHR_W-1:0];
				CFG_ZCR_THR:       cfg_q.zcr_thr       <= cfg_data[ZTHR_W-1:0];
				CFG_SILENCE_LIMIT: cfg_q.silence_limit <= cfg_data[LEN_W-1:0];
				CFG_MIN_SEGMENT:   cfg_q.min_segment   <= cfg_data[LEN_W-1:0];
				CFG_FLUSH_MIN:     cfg_q.flush_min     <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/ezvad_front.sv
module ezvad_front import ezvad_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tlast,
	input  logic                s_tuser,
	output logic                out_valid,
	input  logic                out_ready,
	output sq_t                 out_item
);

	logic                       v_s1, v_s2;
	logic                       en_s1, en_s2;
	logic                       flush_s1, last_s1;
	logic signed [SAMPLE_W-1:0] a_s1, b_s1;
	logic signed [MIX_W-1:0]    x;
	logic signed [2*MIX_W-1:0]  sq_full;
	sq_t                        item_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// Downmix to a 17-bit value in 1/65536 of full scale, then square.
	always_comb begin
		if (cfg.channel_mode)
			x = MIX_W'(a_s1) + MIX_W'(b_s1);
		else
			x = {a_s1, 1'b0};
		sq_full = x * x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= s_tvalid;
			if (en_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			flush_s1 <= s_tuser;
			last_s1  <= s_tlast;
			a_s1     <= s_tdata[SAMPLE_W-1:0];
			b_s1     <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
		if (en_s2 && v_s1) begin
			item_s2.flush <= flush_s1;
			item_s2.last  <= last_s1;
			item_s2.nn    <= !x[MIX_W-1];
			item_s2.sq    <= sq_full[SQ_W-1:0];
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

### hw/rtl/ezvad_frame.sv
module ezvad_frame import ezvad_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sq_t    in_item,
	output logic   out_valid,
	input  logic   out_ready,
	output frame_t out_item
);

	logic [ENERGY_W-1:0] energy_q, energy_n;
	logic [ENERGY_W:0]   energy_sum;
	logic [CNT_W-1:0]    cross_q, cross_n;
	logic [CNT_W-1:0]    cnt_q, cnt_n;
	logic                prev_q;
	logic                frame_end;
	logic                en_s3, v_s3, take;
	frame_t              item_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign in_ready = en_s3;
	assign take     = in_valid && en_s3;

	always_comb begin
		energy_sum = {1'b0, energy_q} + (ENERGY_W+1)'(in_item.sq);
		energy_n   = energy_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_sum[ENERGY_W-1:0];
		cross_n    = cross_q + CNT_W'(cnt_q != '0 && in_item.nn != prev_q);
		cnt_n      = cnt_q + CNT_W'(1);
		frame_end  = in_item.last || cnt_n == CNT_W'(FRAME_MAX);
	end

	// Clear the frame on its end or on a flush; a flush drops a partial frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			cross_q  <= '0;
			cnt_q    <= '0;
			prev_q   <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			if (en_s3)
				v_s3 <= in_valid && (in_item.flush || frame_end);
			if (take) begin
				if (in_item.flush || frame_end) begin
					energy_q <= '0;
					cross_q  <= '0;
					cnt_q    <= '0;
					prev_q   <= 1'b0;
				end else begin
					energy_q <= energy_n;
					cross_q  <= cross_n;
					cnt_q    <= cnt_n;
					prev_q   <= in_item.nn;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s3.flush     <= in_item.flush;
			item_s3.energy    <= energy_n;
			item_s3.crossings <= cross_n;
			item_s3.n         <= cnt_n;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

	a_count_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(FRAME_MAX))
		else $error("frame count reached the frame limit without closing");

	a_cross_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		cross_q < cnt_q || cross_q == '0)
		else $error("crossing count not below item count");

endmodule

### hw/rtl/ezvad_classify.sv
module ezvad_classify import ezvad_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  frame_t in_item,
	output logic   out_valid,
	input  logic   out_ready,
	output prod_t  out_item
);

	logic  en_s4, v_s4;
	prod_t item_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en_s4)
			v_s4 <= in_valid;
	end

	// Scale both thresholds by the frame's item count so the compare needs no divide.
	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			item_s4.flush     <= in_item.flush;
			item_s4.energy    <= in_item.energy;
			item_s4.crossings <= in_item.crossings;
			item_s4.n         <= in_item.n;
			item_s4.elim      <= ELIM_W'(cfg.energy_thr) * ELIM_W'(in_item.n);
			item_s4.zlim      <= ZLIM_W'(cfg.zcr_thr) * ZLIM_W'(in_item.n);
		end
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;

endmodule

### hw/rtl/ezvad_segment.sv
module ezvad_segment import ezvad_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  prod_t               in_item,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic [1:0]          m_tuser
);

	logic             trig_q, trig_d;
	logic [LEN_W-1:0] sil_q, sil_d;
	logic [LEN_W-1:0] seg_q, seg_d;
	logic [LEN_W-1:0] seg_add, sil_add, start_len, len;
	logic             speech;
	event_t           ev;
	logic             en_out, valid_q;
	logic             speech_q, active_q;
	event_t           ev_q;
	logic [LEN_W-1:0] len_q;

	function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
		input logic [CNT_W-1:0] n);
		logic [LEN_W:0] s;
		s = {1'b0, a} + (LEN_W+1)'(n);
		return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
	endfunction

	assign en_out   = !valid_q || m_tready;
	assign in_ready = en_out;

	always_comb begin
		speech = !in_item.flush &&
			(ECMP_W'(in_item.energy) > ECMP_W'(in_item.elim) ||
			 ZLIM_W'({in_item.crossings, {ZCR_SHIFT{1'b0}}}) > in_item.zlim);
		seg_add   = sat_add(seg_q, in_item.n);
		sil_add   = sat_add(sil_q, in_item.n);
		start_len = sat_add('0, in_item.n);
		ev        = EV_NONE;
		len       = '0;
		trig_d    = trig_q;
		sil_d     = sil_q;
		seg_d     = seg_q;
		if (in_item.flush) begin
			if (trig_q && seg_q != '0) begin
				len = seg_q;
				ev  = (seg_q >= cfg.flush_min) ? EV_COMPLETE : EV_DISCARD;
			end
			trig_d = 1'b0;
			sil_d  = '0;
			seg_d  = '0;
		end else if (speech && !trig_q) begin
			trig_d = 1'b1;
			sil_d  = '0;
			seg_d  = start_len;
			ev     = EV_START;
			len    = start_len;
		end else if (speech) begin
			sil_d = '0;
			seg_d = seg_add;
		end else if (trig_q) begin
			sil_d = sil_add;
			seg_d = seg_add;
			// A saturated silence limit can never be exceeded.
			if (sil_add > cfg.silence_limit) begin
				len    = seg_add;
				ev     = (seg_add < cfg.min_segment) ? EV_DISCARD : EV_COMPLETE;
				trig_d = 1'b0;
				sil_d  = '0;
				seg_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q  <= 1'b0;
			sil_q   <= '0;
			seg_q   <= '0;
			valid_q <= 1'b0;
		end else if (en_out) begin
			valid_q <= in_valid;
			if (in_valid) begin
				trig_q <= trig_d;
				sil_q  <= sil_d;
				seg_q  <= seg_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && in_valid) begin
			speech_q <= speech;
			ev_q     <= ev;
			len_q    <= len;
			active_q <= trig_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = ev_q;
	assign m_tdata  = {{(M_DATA_W-LEN_W-2){1'b0}}, active_q, len_q, speech_q};

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && ev_q == EV_START |-> active_q && len_q != '0)
		else $error("segment start without an open segment");

	a_close_shuts: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (ev_q == EV_COMPLETE || ev_q == EV_DISCARD) |-> !active_q && len_q != '0)
		else $error("closed segment still open or empty");

	a_none_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && ev_q == EV_NONE |-> len_q == '0)
		else $error("length reported without an event");

endmodule

### hw/rtl/energy_zcr_vad_segmenter.sv
// Channel  | Dir | Handshake          | Content
// ---------+-----+--------------------+---------------------------------------------
// s_       | in  | s_tvalid/s_tready  | tdata: sample_a, sample_b; tlast: frame_last;
//          |     |                    | tuser: mode (1 = flush)
// m_       | out | m_tvalid/m_tready  | tdata: frame_speech, segment_length, active;
//          |     |                    | tuser: event_res
// cfg_     | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// One item is taken every cycle while s_tready is high. A result appears on m_ once the
// item which ends its frame (or the flush) has passed the five registers in line: input,
// square, frame accumulator, threshold multiply, segment state and result; items inside
// a frame produce no result.
// Reset clears all accumulators and the open segment and loads register defaults.
// A stalled m_tready holds the result; stages above keep filling bubbles, and
// s_tready drops only once every stage is full.
module energy_zcr_vad_segmenter import ezvad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // [15:0] sample_a, [31:16] sample_b
	input  logic                  s_tlast,  // frame_last
	input  logic                  s_tuser,  // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,  // [0] frame_speech, [24:1] segment_length,
	                                        // [25] active, rest zero
	output logic [1:0]            m_tuser   // event_res
);

	cfg_t   cfg;
	logic   sq_valid, sq_ready;
	sq_t    sq_item;
	logic   fr_valid, fr_ready;
	frame_t fr_item;
	logic   pr_valid, pr_ready;
	prod_t  pr_item;

	// Register file: the user must write it only while the pipeline is empty; not enforced here.
	ezvad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Capture the item, downmix and square.
	ezvad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_item  (sq_item)
	);

	// Sum energy and crossings over the frame; pass on one item per frame end or flush.
	ezvad_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_item   (sq_item),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	// Scale thresholds by the frame length.
	ezvad_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (fr_item),
		.out_valid (pr_valid),
		.out_ready (pr_ready),
		.out_item  (pr_item)
	);

	// Decide speech, advance the segment state and hold the result.
	ezvad_segment u_segment (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (pr_valid),
		.in_ready (pr_ready),
		.in_item  (pr_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### dv/vad_result_checker.sv
module vad_result_checker import ezvad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // [15:0] sample_a, [31:16] sample_b
	input  logic                  s_tlast,  // frame_last
	input  logic                  s_tuser,  // mode
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_DATA_W-1:0]   m_tdata,  // [0] frame_speech, [24:1] segment_length,
	                                        // [25] active, rest zero
	input  logic [1:0]            m_tuser,  // event_res
	output int                    mismatches,
	output int                    outstanding
);

	localparam longint ENERGY_CEIL = (longint'(1) << ENERGY_W) - 1;
	localparam longint LEN_CEIL    = (longint'(1) << LEN_W) - 1;

	typedef struct packed {
		logic             speech;
		event_t           ev;
		logic [LEN_W-1:0] seg_len;
		logic             active;
	} vad_result_t;

	cfg_t                regs;
	logic [ENERGY_W-1:0] frame_energy;
	int unsigned         frame_crossings;
	int unsigned         frame_items;
	bit                  last_nonneg;
	bit                  seg_open;
	logic [LEN_W-1:0]    quiet_run;
	logic [LEN_W-1:0]    seg_samples;
	vad_result_t         due_results[$];

	function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] acc,
			input int unsigned n);
		longint sum;
		sum = longint'(acc) + longint'(n);
		return (sum > LEN_CEIL) ? LEN_W'(LEN_CEIL) : LEN_W'(sum);
	endfunction

	task automatic clear_frame();
		frame_energy    = '0;
		frame_crossings = 0;
		frame_items     = 0;
		last_nonneg     = 1'b0;
	endtask

	task automatic close_segment();
		seg_open    = 1'b0;
		quiet_run   = '0;
		seg_samples = '0;
	endtask

	// Advance the detector by one item; made is set when the item yields a result.
	task automatic vad_step(input bit flush, input logic [15:0] a_raw,
			input logic [15:0] b_raw, input bit last, output bit made,
			output vad_result_t r);
		logic signed [16:0] mix;
		longint             sq;
		longint             total;
		int unsigned        n;
		bit                 nn;
		bit                 speech;
		r    = '0;
		r.ev = EV_NONE;
		made = 1'b0;
		if (flush) begin
			if (seg_open && seg_samples != '0) begin
				r.seg_len = seg_samples;
				r.ev      = (seg_samples >= regs.flush_min) ? EV_COMPLETE : EV_DISCARD;
			end
			close_segment();
			clear_frame();
			made = 1'b1;
			return;
		end
		if (regs.channel_mode)
			mix = $signed(a_raw) + $signed(b_raw);
		else
			mix = $signed({a_raw, 1'b0});
		sq = longint'(mix) * longint'(mix);
		nn = !mix[16];
		if (frame_items > 0 && nn != last_nonneg)
			frame_crossings++;
		last_nonneg  = nn;
		total        = longint'(frame_energy) + sq;
		frame_energy = (total > ENERGY_CEIL) ? ENERGY_W'(ENERGY_CEIL) : ENERGY_W'(total);
		frame_items++;
		if (!last && frame_items < FRAME_MAX)
			return;

		n      = frame_items;
		speech = (longint'(frame_energy) > longint'(regs.energy_thr) * longint'(n)) ||
			((longint'(frame_crossings) << ZCR_SHIFT) > longint'(regs.zcr_thr) * longint'(n));
		clear_frame();

		if (speech && !seg_open) begin
			seg_open    = 1'b1;
			quiet_run   = '0;
			seg_samples = len_add('0, n);
			r.ev        = EV_START;
			r.seg_len   = seg_samples;
		end else if (speech) begin
			quiet_run   = '0;
			seg_samples = len_add(seg_samples, n);
		end else if (seg_open) begin
			quiet_run   = len_add(quiet_run, n);
			seg_samples = len_add(seg_samples, n);
			if (quiet_run > regs.silence_limit) begin
				r.seg_len = seg_samples;
				r.ev      = (seg_samples < regs.min_segment) ? EV_DISCARD : EV_COMPLETE;
				close_segment();
			end
		end
		r.speech = speech;
		r.active = seg_open;
		made     = 1'b1;
	endtask

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vad_result_t want;
		bit          made;
		if (!arst_n) begin
			regs.channel_mode  = RST_CHANNEL_MODE;
			regs.energy_thr    = RST_ENERGY_THR;
			regs.zcr_thr       = RST_ZCR_THR;
			regs.silence_limit = RST_SILENCE;
			regs.min_segment   = RST_MIN_SEGMENT;
			regs.flush_min     = RST_FLUSH_MIN;
			clear_frame();
			close_segment();
			due_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHANNEL_MODE:  regs.channel_mode  = cfg_data[0];
					CFG_ENERGY_THR:    regs.energy_thr    = cfg_data[ETHR_W-1:0];
					CFG_ZCR_THR:       regs.zcr_thr       = cfg_data[ZTHR_W-1:0];
					CFG_SILENCE_LIMIT: regs.silence_limit = cfg_data[LEN_W-1:0];
					CFG_MIN_SEGMENT:   regs.min_segment   = cfg_data[LEN_W-1:0];
					CFG_FLUSH_MIN:     regs.flush_min     = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				vad_step(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tlast, made, want);
				if (made)
					due_results.insert(due_results.size(), want);
			end
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, got tdata=%h tuser=%0d",
						$time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("frame_speech", want.speech, m_tdata[0]);
					check_field("event_res", want.ev, m_tuser);
					check_field("segment_length", want.seg_len, m_tdata[LEN_W:1]);
					check_field("active", want.active, m_tdata[LEN_W+1]);
					check_field("tdata padding", 0, m_tdata[M_DATA_W-1:LEN_W+2]);
				end
			end
			outstanding <= due_results.size();
		end
	end

endmodule

### dv/tb.sv
// Stimulus and verdict for the energy / zero-crossing speech segmenter.
// The checker beside the block predicts every result and counts mismatches;
// this module only shapes traffic, writes registers while the block is idle
// and decides the outcome.
module tb;
	import ezvad_pkg::*;

	localparam int HALF_PERIOD    = 2;
	localparam int RESET_CYCLES   = 7;
	localparam int RAND_ITEMS     = 1700;
	localparam int PHASES         = 6;
	localparam int HOLD_CYCLES    = 300;
	// Settle time after the last result, so items that yield no result drain before a write.
	localparam int DRAIN_CYCLES   = 8;
	// Longest legal quiet stretch is the sink hold-off; the limit lies above it.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int OVERSIZE_ITEMS = FRAME_MAX + 4;

	// Register slots past the end of the list; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum int {SLOW_SINK, SLOW_SOURCE, FULL_RATE} idle_mode_e;
	typedef enum int {FR_LOUD, FR_QUIET, FR_BUZZ, FR_NOISE} frame_kind_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;  // [15:0] sample_a, [31:16] sample_b
	logic                  s_tlast   = 1'b0; // frame_last
	logic                  s_tuser   = 1'b0; // mode
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;  // [0] frame_speech, [24:1] segment_length, [25] active
	logic [1:0]            m_tuser;  // event_res

	int         mismatches;
	int         outstanding;
	int         items_sent   = 0;
	int         hold_reqs    = 0;
	int         holds_served = 0;
	int         hold_left    = 0;
	int         quiet_cycles = 0;
	idle_mode_e idle_mode    = FULL_RATE;

	energy_zcr_vad_segmenter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	vad_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #HALF_PERIOD clk = ~clk;

	// Percentage of cycles in which one side idles under the current mode.
	function automatic int idle_pct(input idle_mode_e m, input bit sink);
		case (m)
			SLOW_SINK:   return sink ? 75 : 7;
			SLOW_SOURCE: return sink ? 7 : 75;
			default:     return 0;
		endcase
	endfunction

	// Result sink: a requested hold-off wins over the random stall pattern.
	always @(posedge clk) begin
		if (holds_served != hold_reqs) begin
			holds_served <= holds_served + 1;
			hold_left    <= HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= idle_pct(idle_mode, 1'b1));
		end
	end

	// Watchdog: end the run when neither channel has moved an item for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one item after a random gap and hold it until it is taken.
	// Leave tvalid high on return so back-to-back items need no extra edge.
	task automatic send_item(input bit flush, input logic [15:0] a, input logic [15:0] b,
			input bit last);
		while ($urandom_range(0, 99) < idle_pct(idle_mode, 1'b0)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tlast  <= last;
		s_tuser  <= flush;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_flush();
		send_item(1'b1, 16'($urandom), 16'($urandom), 1'($urandom));
	endtask

	// Mostly short frames, now and then a longer one.
	function automatic int frame_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
	endfunction

	// Send a frame of the given character; drop the last mark to leave it open.
	task automatic send_frame(input frame_kind_e kind, input int len, input bit closed);
		logic [15:0] a;
		logic [15:0] b;
		int          mag;
		for (int i = 0; i < len; i++) begin
			case (kind)
				FR_LOUD: begin
					a = 16'($urandom);
					b = 16'($urandom);
				end
				FR_QUIET: begin
					// small and never negative: little energy, no crossings
					a = 16'($urandom_range(0, 40));
					b = 16'($urandom_range(0, 40));
				end
				FR_BUZZ: begin
					// low level, sign flips every item: high crossing rate
					mag = $urandom_range(1, 60);
					a   = (i % 2) ? 16'(-mag) : 16'(mag);
					b   = a;
				end
				default: begin
					a = 16'($urandom_range(0, 4000)) - 16'd2000;
					b = 16'($urandom_range(0, 4000)) - 16'd2000;
				end
			endcase
			send_item(1'b0, a, b, closed && (i == len - 1));
		end
	endtask

	// Drop tvalid and hold until every predicted result has arrived;
	// with settle, also let items that yield no result clear the pipeline.
	task automatic wait_results_done(input bit settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		if (settle)
			repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register; with junk, fill the bits above its width at random.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
			input int width, input bit junk);
		logic [CFG_DATA_W-1:0] word;
		word = value;
		if (junk)
			for (int i = width; i < CFG_DATA_W; i++)
				word[i] = 1'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
	endtask

	// Load a full register set back to back, then release the write enable.
	task automatic apply_config(input cfg_t c, input bit junk);
		put_reg(CFG_CHANNEL_MODE, CFG_DATA_W'(c.channel_mode), 1, junk);
		put_reg(CFG_ENERGY_THR, c.energy_thr, ETHR_W, junk);
		put_reg(CFG_ZCR_THR, CFG_DATA_W'(c.zcr_thr), ZTHR_W, junk);
		put_reg(CFG_SILENCE_LIMIT, CFG_DATA_W'(c.silence_limit), LEN_W, junk);
		put_reg(CFG_MIN_SEGMENT, CFG_DATA_W'(c.min_segment), LEN_W, junk);
		put_reg(CFG_FLUSH_MIN, CFG_DATA_W'(c.flush_min), LEN_W, junk);
		if (junk) begin
			put_reg(CFG_SPARE_LO, CFG_DATA_W'({$urandom, $urandom}), CFG_DATA_W, 1'b0);
			put_reg(CFG_SPARE_HI, CFG_DATA_W'({$urandom, $urandom}), CFG_DATA_W, 1'b0);
		end
		cfg_we <= 1'b0;
	endtask

	// Well-formed speech / silence runs with random content, plus noise,
	// flushes and frames cut short by a flush.
	task automatic run_segments(input int budget);
		int first;
		int pick;
		first = items_sent;
		while (items_sent - first < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				repeat ($urandom_range(1, 4))
					send_frame($urandom_range(0, 1) ? FR_LOUD : FR_BUZZ, frame_len(), 1'b1);
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 6))
					send_frame(FR_QUIET, frame_len(), 1'b1);
			end else if (pick < 85) begin
				send_frame(FR_NOISE, frame_len(), 1'b1);
			end else if (pick < 93) begin
				send_flush();
			end else begin
				send_frame(FR_NOISE, frame_len(), 1'b0);
				send_flush();
			end
		end
	endtask

	initial begin
		cfg_t dir_cfg;
		cfg_t plan [PHASES];

		// Short lengths so segments open and close within a few frames.
		plan[0] = '{channel_mode: 1'b1, energy_thr: RST_ENERGY_THR, zcr_thr: RST_ZCR_THR,
			silence_limit: 24, min_segment: 40, flush_min: 12};
		// Any energy is speech, crossing rate can never win, one silent frame closes.
		plan[1] = '{channel_mode: 1'b0, energy_thr: '0, zcr_thr: 17'd65536,
			silence_limit: '0, min_segment: '0, flush_min: '0};
		// Energy can never win, any crossing is speech.
		plan[2] = '{channel_mode: 1'b1, energy_thr: 33'h1_0000_0000, zcr_thr: '0,
			silence_limit: 8, min_segment: 16, flush_min: 16};
		// Silence never closes; every flush discards an open segment.
		plan[3] = '{channel_mode: 1'b0, energy_thr: 1000000, zcr_thr: '1,
			silence_limit: '1, min_segment: '1, flush_min: '1};
		plan[4] = '{channel_mode: 1'b1, energy_thr: 50000000, zcr_thr: 20000,
			silence_limit: 60, min_segment: 100, flush_min: 1};
		plan[5] = '{channel_mode: 1'b0, energy_thr: '1, zcr_thr: RST_ZCR_THR,
			silence_limit: 16, min_segment: 30, flush_min: 8};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset register values, stereo.
		send_item(1'b0, 16'h7FFF, 16'h7FFF, 1'b0);  // full-scale positive pair
		send_item(1'b0, 16'h8000, 16'h8000, 1'b1);  // full-scale negative: opens a segment
		send_item(1'b0, 16'h0000, 16'h0000, 1'b0);  // zero counts as nonnegative
		send_item(1'b0, 16'hFFFF, 16'h0000, 1'b0);
		send_item(1'b0, 16'h0000, 16'h0000, 1'b1);
		send_item(1'b0, 16'h0064, 16'h0000, 1'b0);  // left open: flush drops it
		send_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b1);  // flush a short open segment
		send_item(1'b1, 16'h0000, 16'h0000, 1'b0);  // flush with nothing open
		wait_results_done(1'b1);

		// Mono, tiny silence limit: closes on silence, short and long.
		dir_cfg = '{channel_mode: 1'b0, energy_thr: RST_ENERGY_THR, zcr_thr: RST_ZCR_THR,
			silence_limit: 2, min_segment: 5, flush_min: RST_FLUSH_MIN};
		apply_config(dir_cfg, 1'b1);
		send_item(1'b0, 16'h8000, 16'h7FFF, 1'b1);  // most negative mono value, b ignored
		send_item(1'b0, 16'h0005, 16'h8000, 1'b0);
		send_item(1'b0, 16'h0005, 16'h0000, 1'b0);
		send_item(1'b0, 16'h0005, 16'hFFFF, 1'b1);  // silence past limit: too short, discard
		send_item(1'b0, 16'h7FFF, 16'h0000, 1'b0);
		send_item(1'b0, 16'h7FFF, 16'h8000, 1'b1);  // reopen
		send_item(1'b0, 16'h0000, 16'h0000, 1'b0);
		send_item(1'b0, 16'h0000, 16'h7FFF, 1'b0);
		send_item(1'b0, 16'h0000, 16'h0000, 1'b1);  // closes complete
		send_flush();

		// Random part: each phase gets its own register set and idle pattern.
		for (int p = 0; p < PHASES; p++) begin
			wait_results_done(1'b1);
			apply_config(plan[p], p[0]);
			idle_mode <= (p < 2) ? SLOW_SINK : ((p < 4) ? SLOW_SOURCE : FULL_RATE);
			// Stall the sink for a long stretch while items keep coming.
			if (p == 4)
				hold_reqs <= hold_reqs + 1;
			// Oversized frame at full scale: ends itself and saturates the energy sum.
			if (p == 5)
				for (int i = 0; i < OVERSIZE_ITEMS; i++)
					send_item(1'b0, 16'h8000, 16'($urandom), i == OVERSIZE_ITEMS - 1);
			run_segments(RAND_ITEMS / PHASES / 2);
			// Pause the source until every result is back.
			if (p == 3)
				wait_results_done(1'b0);
			run_segments(RAND_ITEMS / PHASES / 2);
		end

		wait_results_done(1'b1);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
